// ----- sv/ibs_pkg.sv -----
package ibs_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int PHASE_W = 5;
  localparam int QUEUE_DEPTH = 2;

  // final phase index of each command's run
  localparam logic [PHASE_W-1:0] START_LAST = PHASE_W'(3);
  localparam logic [PHASE_W-1:0] STOP_LAST = PHASE_W'(2);
  localparam logic [PHASE_W-1:0] WR_LAST = PHASE_W'(3 * BITS_PER_BYTE + 3);
  localparam logic [PHASE_W-1:0] RD_LAST = PHASE_W'(2 * BITS_PER_BYTE + 4);

  // boundaries of the bit sections
  localparam logic [PHASE_W-1:0] WR_BITS_END = PHASE_W'(3 * BITS_PER_BYTE);
  localparam logic [PHASE_W-1:0] RD_BITS_END = PHASE_W'(2 * BITS_PER_BYTE);

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  // sub-step of one written bit
  typedef enum logic [1:0] {
    WR_DATA = 2'd0,
    WR_HIGH = 2'd1,
    WR_LOW  = 2'd2
  } wr_step_t;

  typedef struct packed {
    op_t                op;
    logic               send_ack;
    logic [7:0]         tx_byte;
    logic [7:0]         rx_bits;
    logic               ack_level;
    logic [PHASE_W-1:0] last_phase;
  } cmd_t;

endpackage

// ----- sv/ibs_if.sv -----
interface ibs_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic       send_ack;
  logic [7:0] tx_byte;
  logic [7:0] rx_bits;
  logic       ack_level;

  modport source (output valid, operation, send_ack, tx_byte, rx_bits, ack_level,
                  input ready);
  modport sink (input valid, operation, send_ack, tx_byte, rx_bits, ack_level,
                output ready);
endinterface

interface ibs_phase_if;
  logic       valid;
  logic       ready;
  logic       scl;
  logic       sda;
  logic [7:0] rx_byte;
  logic       nack_seen;
  logic       last;

  modport source (output valid, scl, sda, rx_byte, nack_seen, last, input ready);
  modport sink (input valid, scl, sda, rx_byte, nack_seen, last, output ready);
endinterface

// ----- sv/ibs_front.sv -----
module ibs_front
  import ibs_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  ibs_cmd_if.sink  in_ch,
  output logic     q_valid,
  output cmd_t     q_cmd,
  input  logic     q_pop
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  cmd_t          cmd_in;
  logic          push;
  op_t           op_in;

  // decode the command and fix its run length up front
  always_comb begin
    op_in = op_t'(in_ch.operation);
    cmd_in.op = op_in;
    cmd_in.send_ack = in_ch.send_ack;
    cmd_in.tx_byte = in_ch.tx_byte;
    cmd_in.rx_bits = in_ch.rx_bits;
    cmd_in.ack_level = in_ch.ack_level;
    case (op_in)
      OP_START: cmd_in.last_phase = START_LAST;
      OP_STOP:  cmd_in.last_phase = STOP_LAST;
      OP_WRITE: cmd_in.last_phase = WR_LAST;
      OP_READ:  cmd_in.last_phase = RD_LAST;
      default:  cmd_in.last_phase = START_LAST;
    endcase
  end

  assign in_ch.ready = (count_r != CW'(DEPTH));
  assign push = in_ch.valid && in_ch.ready;
  assign q_valid = (count_r != '0);
  assign q_cmd = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (q_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    case ({push, q_pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

// ----- sv/ibs_back.sv -----
module ibs_back
  import ibs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  cmd_t        q_cmd,
  output logic        q_pop,
  ibs_phase_if.source out_ch
);

  cmd_t               cmd_r, cmd_nxt;
  logic               active_r, active_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  wr_step_t           step_r, step_nxt;
  logic [7:0]         shift_r, shift_nxt;
  logic               scl_lvl_r, scl_lvl_nxt;
  logic               sda_lvl_r, sda_lvl_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_scl_r, out_sda_r, out_nack_r, out_last_r;
  logic [7:0]         out_rx_r;

  logic               adv;
  logic               is_last;
  logic               ph_scl, ph_sda, ph_nack;
  logic [7:0]         ph_rx;

  assign adv = active_r && (!out_valid_r || out_ch.ready);
  assign is_last = (phase_r == cmd_r.last_phase);
  assign q_pop = q_valid && (!active_r || (adv && is_last));

  // line levels of the current phase and the shifter update
  always_comb begin
    ph_scl = scl_lvl_r;
    ph_sda = sda_lvl_r;
    ph_nack = 1'b0;
    ph_rx = '0;
    shift_nxt = shift_r;
    step_nxt = step_r;
    case (cmd_r.op)
      OP_START: begin
        case (phase_r)
          PHASE_W'(0): ph_sda = 1'b1;
          PHASE_W'(1): ph_scl = 1'b1;
          PHASE_W'(2): ph_sda = 1'b0;
          default:     ph_scl = 1'b0;
        endcase
      end
      OP_STOP: begin
        case (phase_r)
          PHASE_W'(0): ph_sda = 1'b0;
          PHASE_W'(1): ph_scl = 1'b1;
          default:     ph_sda = 1'b1;
        endcase
      end
      OP_WRITE: begin
        if (phase_r == '0) begin
          ph_scl = 1'b0;
          shift_nxt = cmd_r.tx_byte;
          step_nxt = WR_DATA;
        end else if (phase_r <= WR_BITS_END) begin
          case (step_r)
            WR_DATA: begin
              ph_sda = shift_r[7];
              step_nxt = WR_HIGH;
            end
            WR_HIGH: begin
              ph_scl = 1'b1;
              step_nxt = WR_LOW;
            end
            default: begin
              ph_scl = 1'b0;
              shift_nxt = {shift_r[6:0], 1'b0};
              step_nxt = WR_DATA;
            end
          endcase
        end else if (phase_r == WR_BITS_END + PHASE_W'(1)) begin
          ph_sda = 1'b1;
        end else if (phase_r == WR_BITS_END + PHASE_W'(2)) begin
          ph_scl = 1'b1;
        end else begin
          ph_scl = 1'b0;
          ph_nack = cmd_r.ack_level;
        end
      end
      default: begin
        // read
        if (phase_r == '0) begin
          ph_sda = 1'b1;
        end else if (phase_r <= RD_BITS_END) begin
          ph_scl = !phase_r[0];
        end else if (phase_r == RD_BITS_END + PHASE_W'(1)) begin
          ph_scl = 1'b0;
        end else if (phase_r == RD_BITS_END + PHASE_W'(2)) begin
          ph_sda = !cmd_r.send_ack;
        end else if (phase_r == RD_BITS_END + PHASE_W'(3)) begin
          ph_scl = 1'b1;
        end else begin
          ph_scl = 1'b0;
          ph_rx = cmd_r.rx_bits;
        end
      end
    endcase
  end

  always_comb begin
    cmd_nxt = cmd_r;
    active_nxt = active_r;
    phase_nxt = phase_r;
    scl_lvl_nxt = scl_lvl_r;
    sda_lvl_nxt = sda_lvl_r;
    out_valid_nxt = out_valid_r;
    if (adv) begin
      scl_lvl_nxt = ph_scl;
      sda_lvl_nxt = ph_sda;
      out_valid_nxt = 1'b1;
      phase_nxt = phase_r + PHASE_W'(1);
      if (is_last) begin
        active_nxt = 1'b0;
      end
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (q_pop) begin
      cmd_nxt = q_cmd;
      active_nxt = 1'b1;
      phase_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      phase_r <= '0;
      step_r <= WR_DATA;
      shift_r <= '0;
      scl_lvl_r <= 1'b1;
      sda_lvl_r <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
      phase_r <= phase_nxt;
      scl_lvl_r <= scl_lvl_nxt;
      sda_lvl_r <= sda_lvl_nxt;
      out_valid_r <= out_valid_nxt;
      if (adv) begin
        step_r <= step_nxt;
        shift_r <= shift_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    if (adv) begin
      out_scl_r <= ph_scl;
      out_sda_r <= ph_sda;
      out_rx_r <= ph_rx;
      out_nack_r <= ph_nack;
      out_last_r <= is_last;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.scl = out_scl_r;
  assign out_ch.sda = out_sda_r;
  assign out_ch.rx_byte = out_rx_r;
  assign out_ch.nack_seen = out_nack_r;
  assign out_ch.last = out_last_r;

endmodule

// ----- sv/i2c_master_byte_sequencer_core.sv -----
// an item goes from the queue through the back's command register into the output register
// throughput: one phase per cycle from the back sequencer; start 4, stop 3, read 21 and
//   write 28 phases per item, back to back with no gap while results are taken
// the command queue lets new items in while the sequencer still drives earlier ones
// reset (rst_n low, synchronous): queue empty, sequencer idle, scl and sda levels high
module i2c_master_byte_sequencer_core
  import ibs_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  ibs_cmd_if.sink     in_ch,
  ibs_phase_if.source out_ch
);

  // queue head handed from the front to the back
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  // front: takes commands, decodes the run length, buffers them
  ibs_front #(
    .DEPTH (QDEPTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop)
  );

  // back: steps through the phases of one command, one per cycle while the receiver takes
  // them, into an output register; bus levels carry over from one command to the next
  ibs_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb
  import ibs_pkg::*;
();

  localparam int RANDOM_ITEMS = 290;
  localparam int IDLE_PCT = 24;
  localparam int CYCLE_LIMIT = 250000;
  localparam int DRAIN_CYCLES = 8;

  // one bus command as the driver presents it
  typedef struct {
    op_t        op;
    logic       send_ack;
    logic [7:0] tx_byte;
    logic [7:0] rx_bits;
    logic       ack_level;
  } bus_cmd_t;

  // one bus phase as the block reports it
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic [7:0] rx_byte;
    logic       nack_seen;
    logic       last;
  } bus_phase_t;

  // directed stimulus row, with the final phase's read byte and ack flag pinned where obvious
  typedef struct {
    bus_cmd_t   cmd;
    bit         pinned;
    logic [7:0] pin_rx;
    logic       pin_nack;
  } cmd_row_t;

  logic clk = 1'b0;
  logic rst_n;

  ibs_cmd_if   cmd_if();
  ibs_phase_if phase_if();

  i2c_master_byte_sequencer_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (cmd_if),
    .out_ch (phase_if)
  );

  // bus levels and shifter tracked by the predictor
  logic       bus_scl;
  logic       bus_sda;
  logic [7:0] shifter;

  bus_phase_t pending_phases[$];
  cmd_row_t   directed_rows[$];

  int  errors;
  int  phases_checked;
  int  cycles;
  int  ops_sent[4];
  bit  steady;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // idle or stall in this cycle, never during the steady stretch
  function automatic bit take_break();
    return !steady && ($urandom_range(0, 99) < IDLE_PCT);
  endfunction

  function automatic void push_phase(logic fin, logic [7:0] rx, logic nack);
    bus_phase_t p;
    p.scl = bus_scl;
    p.sda = bus_sda;
    p.rx_byte = rx;
    p.nack_seen = nack;
    p.last = fin;
    pending_phases.push_back(p);
  endfunction

  // expected bus phases for one accepted command, levels carried over between commands
  function automatic void sequence_phases(bus_cmd_t c);
    case (c.op)
      OP_START: begin
        bus_sda = 1'b1; push_phase(1'b0, 8'h00, 1'b0);
        bus_scl = 1'b1; push_phase(1'b0, 8'h00, 1'b0);
        bus_sda = 1'b0; push_phase(1'b0, 8'h00, 1'b0);
        bus_scl = 1'b0; push_phase(1'b1, 8'h00, 1'b0);
      end
      OP_STOP: begin
        bus_sda = 1'b0; push_phase(1'b0, 8'h00, 1'b0);
        bus_scl = 1'b1; push_phase(1'b0, 8'h00, 1'b0);
        bus_sda = 1'b1; push_phase(1'b1, 8'h00, 1'b0);
      end
      OP_WRITE: begin
        shifter = c.tx_byte;
        bus_scl = 1'b0; push_phase(1'b0, 8'h00, 1'b0);
        // msb first: data, clock high, clock low
        for (int i = 0; i < BITS_PER_BYTE; i++) begin
          bus_sda = shifter[7]; push_phase(1'b0, 8'h00, 1'b0);
          bus_scl = 1'b1; push_phase(1'b0, 8'h00, 1'b0);
          bus_scl = 1'b0; push_phase(1'b0, 8'h00, 1'b0);
          shifter = {shifter[6:0], 1'b0};
        end
        // release sda for the ack clock, report the sampled level at the end
        bus_sda = 1'b1; push_phase(1'b0, 8'h00, 1'b0);
        bus_scl = 1'b1; push_phase(1'b0, 8'h00, 1'b0);
        bus_scl = 1'b0; push_phase(1'b1, 8'h00, c.ack_level);
      end
      default: begin
        shifter = 8'h00;
        bus_sda = 1'b1; push_phase(1'b0, 8'h00, 1'b0);
        for (int i = 0; i < BITS_PER_BYTE; i++) begin
          bus_scl = 1'b0; push_phase(1'b0, 8'h00, 1'b0);
          bus_scl = 1'b1;
          shifter = {shifter[6:0], c.rx_bits[BITS_PER_BYTE-1-i]};
          push_phase(1'b0, 8'h00, 1'b0);
        end
        // master ack or nack, sda stays at that level afterwards
        bus_scl = 1'b0; push_phase(1'b0, 8'h00, 1'b0);
        bus_sda = !c.send_ack; push_phase(1'b0, 8'h00, 1'b0);
        bus_scl = 1'b1; push_phase(1'b0, 8'h00, 1'b0);
        bus_scl = 1'b0; push_phase(1'b1, shifter, 1'b0);
      end
    endcase
  endfunction

  function automatic void add_row(op_t op, logic ack, logic [7:0] tx, logic [7:0] rx,
                                  logic lvl, bit pinned, logic [7:0] p_rx, logic p_nack);
    cmd_row_t r;
    r.cmd.op = op;
    r.cmd.send_ack = ack;
    r.cmd.tx_byte = tx;
    r.cmd.rx_bits = rx;
    r.cmd.ack_level = lvl;
    r.pinned = pinned;
    r.pin_rx = p_rx;
    r.pin_nack = p_nack;
    directed_rows.push_back(r);
  endfunction

  function automatic bus_cmd_t random_cmd(op_t op);
    bus_cmd_t c;
    c.op = op;
    c.send_ack = 1'($urandom_range(0, 1));
    c.tx_byte = 8'($urandom_range(0, 255));
    c.rx_bits = 8'($urandom_range(0, 255));
    c.ack_level = 1'($urandom_range(0, 1));
    return c;
  endfunction

  // present one command, wait for the handshake, then record its expected phases
  task automatic issue_command(bus_cmd_t c, bit pinned, logic [7:0] p_rx, logic p_nack);
    bus_phase_t tail;
    if (take_break()) begin
      cmd_if.valid <= 1'b0;
      do @(negedge clk); while (take_break());
    end
    cmd_if.valid <= 1'b1;
    cmd_if.operation <= c.op;
    cmd_if.send_ack <= c.send_ack;
    cmd_if.tx_byte <= c.tx_byte;
    cmd_if.rx_bits <= c.rx_bits;
    cmd_if.ack_level <= c.ack_level;
    do @(posedge clk); while (!(cmd_if.valid && cmd_if.ready));
    sequence_phases(c);
    // pinned rows check the final phase against the hand-written value
    if (pinned) begin
      tail = pending_phases.pop_back();
      tail.rx_byte = p_rx;
      tail.nack_seen = p_nack;
      pending_phases.push_back(tail);
    end
    ops_sent[c.op]++;
    @(negedge clk);
  endtask

  function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
    if (exp_v !== got_v) begin
      errors++;
      $display("%0t ns: phase %0d %s mismatch, expected %0h got %0h",
               $time, phases_checked, name, exp_v, got_v);
    end
  endfunction

  // result monitor: every accepted phase against the oldest expectation
  always @(posedge clk) begin
    bus_phase_t want;
    if (rst_n && phase_if.valid && phase_if.ready) begin
      if (pending_phases.size() == 0) begin
        errors++;
        $display("%0t ns: phase with nothing expected, scl %b sda %b rx %0h nack %b last %b",
                 $time, phase_if.scl, phase_if.sda, phase_if.rx_byte, phase_if.nack_seen,
                 phase_if.last);
      end else begin
        want = pending_phases.pop_front();
        check_field("scl", 8'(want.scl), 8'(phase_if.scl));
        check_field("sda", 8'(want.sda), 8'(phase_if.sda));
        check_field("rx_byte", want.rx_byte, phase_if.rx_byte);
        check_field("nack_seen", 8'(want.nack_seen), 8'(phase_if.nack_seen));
        check_field("last", 8'(want.last), 8'(phase_if.last));
      end
      phases_checked++;
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    phase_if.ready <= rst_n && !take_break();
  end

  // watchdog
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d phases still expected",
             cycles, pending_phases.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int        sent;
    int        n_wr;
    int        n_rd;
    bus_cmd_t  c;
    rst_n = 1'b0;
    steady = 1'b0;
    errors = 0;
    phases_checked = 0;
    sent = 0;
    cmd_if.valid = 1'b0;
    cmd_if.operation = OP_START;
    cmd_if.send_ack = 1'b0;
    cmd_if.tx_byte = 8'h00;
    cmd_if.rx_bits = 8'h00;
    cmd_if.ack_level = 1'b0;
    bus_scl = 1'b1;
    bus_sda = 1'b1;
    shifter = 8'h00;

    // directed: extremes of the bytes, every command, unused fields driven,
    // inherited clock level and sda held at the ack level after a read
    add_row(OP_START, 1'b1, 8'hFF, 8'hFF, 1'b1, 1'b1, 8'h00, 1'b0);
    add_row(OP_WRITE, 1'b1, 8'hFF, 8'hFF, 1'b1, 1'b1, 8'h00, 1'b1);
    add_row(OP_WRITE, 1'b0, 8'h00, 8'h00, 1'b0, 1'b1, 8'h00, 1'b0);
    add_row(OP_WRITE, 1'b0, 8'hA5, 8'h3C, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(OP_READ,  1'b1, 8'hFF, 8'hFF, 1'b1, 1'b1, 8'hFF, 1'b0);
    add_row(OP_READ,  1'b0, 8'hFF, 8'h00, 1'b1, 1'b1, 8'h00, 1'b0);
    add_row(OP_READ,  1'b1, 8'h00, 8'h5A, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(OP_START, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(OP_READ,  1'b0, 8'h00, 8'h81, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(OP_STOP,  1'b1, 8'hFF, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0);
    add_row(OP_STOP,  1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(OP_START, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(OP_START, 1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(OP_STOP,  1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(OP_READ,  1'b1, 8'h00, 8'h7E, 1'b1, 1'b0, 8'h00, 1'b0);
    add_row(OP_WRITE, 1'b1, 8'h80, 8'hFF, 1'b1, 1'b0, 8'h00, 1'b0);
    add_row(OP_READ,  1'b1, 8'h00, 8'h01, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(OP_STOP,  1'b0, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00, 1'b0);
    add_row(OP_READ,  1'b0, 8'hC3, 8'h96, 1'b1, 1'b0, 8'h00, 1'b0);
    add_row(OP_WRITE, 1'b0, 8'h01, 8'h00, 1'b1, 1'b0, 8'h00, 1'b0);

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i])
      issue_command(directed_rows[i].cmd, directed_rows[i].pinned,
                    directed_rows[i].pin_rx, directed_rows[i].pin_nack);

    // random: mostly framed transfers with random content, the rest loose commands
    while (sent < RANDOM_ITEMS) begin
      steady = (sent >= 100) && (sent < 170);
      if ($urandom_range(0, 99) < 80) begin
        n_wr = $urandom_range(1, 3);
        n_rd = $urandom_range(0, 3);
        issue_command(random_cmd(OP_START), 1'b0, 8'h00, 1'b0);
        repeat (n_wr) issue_command(random_cmd(OP_WRITE), 1'b0, 8'h00, 1'b0);
        // repeated start before a read burst now and then
        if (n_rd != 0 && $urandom_range(0, 1))
          issue_command(random_cmd(OP_START), 1'b0, 8'h00, 1'b0);
        for (int k = 0; k < n_rd; k++) begin
          c = random_cmd(OP_READ);
          if (k == n_rd - 1)
            c.send_ack = 1'b0;
          issue_command(c, 1'b0, 8'h00, 1'b0);
        end
        issue_command(random_cmd(OP_STOP), 1'b0, 8'h00, 1'b0);
        sent += n_wr + n_rd + 2;
      end else begin
        issue_command(random_cmd(op_t'($urandom_range(0, 3))), 1'b0, 8'h00, 1'b0);
        sent++;
      end
    end
    steady = 1'b0;
    cmd_if.valid <= 1'b0;

    // drain, then give the block time to show any stray phase
    while (pending_phases.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_phases.size() != 0) begin
      errors++;
      $display("%0t ns: %0d phases never arrived", $time, pending_phases.size());
    end

    $display("sent %0d starts, %0d stops, %0d writes, %0d reads",
             ops_sent[OP_START], ops_sent[OP_STOP], ops_sent[OP_WRITE], ops_sent[OP_READ]);
    $display("checked %0d bus phases in %0d cycles, %0d mismatches",
             phases_checked, cycles, errors);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/ibs_pkg.sv
sv/ibs_if.sv
sv/ibs_front.sv
sv/ibs_back.sv
sv/i2c_master_byte_sequencer_core.sv
tb/tb.sv
